>>> rtl/core/cgr_pkg.sv
package cgr_pkg;

	localparam int PLACE_W = 16;
	localparam int SLOT_W  = 4;
	localparam int OUT_W   = 15;
	localparam int NCH     = 4;
	localparam int CLAMP_W = 40;

	// request kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// color sets carried along the chain
	localparam int SEL_LB = 0;
	localparam int SEL_UA = 1;
	localparam int SEL_MN = 2;
	localparam int SEL_MX = 3;
	localparam int NSEL   = 4;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef struct packed {
		logic               lb_ok;
		logic [PLACE_W-1:0] lb_place;
		logic               ua_ok;
		logic [PLACE_W-1:0] ua_place;
		logic               mn_ok;
		logic [PLACE_W-1:0] mn_place;
		logic               mx_ok;
		logic [PLACE_W-1:0] mx_place;
	} cand_t;

	function automatic logic [OUT_W-1:0] clamp_out(input logic signed [CLAMP_W-1:0] v);
		logic signed [CLAMP_W-1:0] lim;
		lim = signed'({{(CLAMP_W-OUT_W){1'b0}}, OUT_MAX});
		if (v < 0) begin
			return '0;
		end else if (v > lim) begin
			return OUT_MAX;
		end else begin
			return v[OUT_W-1:0];
		end
	endfunction

endpackage

>>> rtl/core/cgr_cell.sv
module cgr_cell #(
	parameter int CB  = 16
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            wr_en,
	input  logic                                            wr_used,
	input  logic [cgr_pkg::PLACE_W-1:0]                     wr_place,
	input  logic [cgr_pkg::NCH-1:0][CB-1:0]                 wr_rgba,
	input  logic                                            tok_in,
	input  logic [cgr_pkg::PLACE_W-1:0]                     q_in,
	input  cgr_pkg::cand_t                                  cand_in,
	input  logic [cgr_pkg::NSEL-1:0][cgr_pkg::NCH-1:0][CB-1:0] sel_in,
	output logic                                            tok_out,
	output logic [cgr_pkg::PLACE_W-1:0]                     q_out,
	output cgr_pkg::cand_t                                  cand_out,
	output logic [cgr_pkg::NSEL-1:0][cgr_pkg::NCH-1:0][CB-1:0] sel_out
);

	logic                              used_q;
	logic [cgr_pkg::PLACE_W-1:0]       place_q;
	logic [cgr_pkg::NCH-1:0][CB-1:0]   rgba_q;
	logic                              tok_q;
	logic [cgr_pkg::PLACE_W-1:0]       q_q;
	cgr_pkg::cand_t                    cand_q;
	logic [cgr_pkg::NSEL-1:0][cgr_pkg::NCH-1:0][CB-1:0] sel_q;

	cgr_pkg::cand_t                    cand_nxt;
	logic [cgr_pkg::NSEL-1:0][cgr_pkg::NCH-1:0][CB-1:0] sel_nxt;

	// strict compares keep the lowest slot among equal places
	always_comb begin
		cand_nxt = cand_in;
		sel_nxt  = sel_in;
		if (used_q) begin
			if (place_q < q_in && (!cand_in.lb_ok || place_q > cand_in.lb_place)) begin
				cand_nxt.lb_ok    = 1'b1;
				cand_nxt.lb_place = place_q;
				sel_nxt[cgr_pkg::SEL_LB] = rgba_q;
			end
			if (place_q >= q_in && (!cand_in.ua_ok || place_q < cand_in.ua_place)) begin
				cand_nxt.ua_ok    = 1'b1;
				cand_nxt.ua_place = place_q;
				sel_nxt[cgr_pkg::SEL_UA] = rgba_q;
			end
			if (!cand_in.mn_ok || place_q < cand_in.mn_place) begin
				cand_nxt.mn_ok    = 1'b1;
				cand_nxt.mn_place = place_q;
				sel_nxt[cgr_pkg::SEL_MN] = rgba_q;
			end
			if (!cand_in.mx_ok || place_q > cand_in.mx_place) begin
				cand_nxt.mx_ok    = 1'b1;
				cand_nxt.mx_place = place_q;
				sel_nxt[cgr_pkg::SEL_MX] = rgba_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (wr_en) begin
				used_q <= wr_used;
			end
		end
	end

	always_ff @(posedge clk) begin
		q_q    <= q_in;
		cand_q <= cand_nxt;
		sel_q  <= sel_nxt;
		if (wr_en && wr_used) begin
			place_q <= wr_place;
			rgba_q  <= wr_rgba;
		end
	end

	assign tok_out  = tok_q;
	assign q_out    = q_q;
	assign cand_out = cand_q;
	assign sel_out  = sel_q;

endmodule

>>> rtl/core/cgr_div.sv
module cgr_div #(
	parameter int CB = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [CB-1:0]                     a,
	input  logic [CB-1:0]                     b,
	input  logic [cgr_pkg::PLACE_W-1:0]       off,
	input  logic [cgr_pkg::PLACE_W-1:0]       span,
	output logic                              done,
	output logic [cgr_pkg::OUT_W-1:0]         res
);

	localparam int DW = cgr_pkg::PLACE_W + 1;
	localparam int NW = cgr_pkg::PLACE_W + CB + 2;
	localparam int MW = cgr_pkg::PLACE_W + CB + 1;
	localparam int PW = cgr_pkg::PLACE_W + CB + 2;
	localparam int QW = CB + 2;
	localparam int CW = $clog2(NW + 1);

	typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV, D_FIN} dstate_t;

	dstate_t                       state_q;
	logic signed [CB-1:0]          a_q;
	logic signed [CB:0]            diff_q;
	logic [cgr_pkg::PLACE_W-1:0]   off_q;
	logic [cgr_pkg::PLACE_W-1:0]   span_q;
	logic                          neg_q;
	logic [NW-1:0]                 num_q;
	logic [DW-1:0]                 den_q;
	logic [DW-1:0]                 rem_q;
	logic [NW-1:0]                 quo_q;
	logic [CW-1:0]                 cnt_q;
	logic                          done_q;
	logic [cgr_pkg::OUT_W-1:0]     res_q;

	logic signed [PW-1:0]          prod;
	logic [MW-1:0]                 mag;
	logic [DW:0]                   trial;
	logic                          qbit;
	logic [DW-1:0]                 rem_nxt;
	logic signed [cgr_pkg::CLAMP_W-1:0] a_ext;
	logic signed [cgr_pkg::CLAMP_W-1:0] q_ext;
	logic signed [cgr_pkg::CLAMP_W-1:0] v;

	always_comb begin
		prod = signed'({1'b0, off_q}) * diff_q;
		mag  = prod[PW-1] ? MW'(-prod) : MW'(prod);
		// one restoring step per cycle
		trial = {rem_q, num_q[NW-1]};
		qbit  = trial >= {1'b0, den_q};
		rem_nxt = qbit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
		a_ext = {{(cgr_pkg::CLAMP_W-CB){a_q[CB-1]}}, a_q};
		q_ext = signed'({{(cgr_pkg::CLAMP_W-QW){1'b0}}, quo_q[QW-1:0]});
		v = neg_q ? a_ext - q_ext : a_ext + q_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					state_q <= D_DIV;
				end
				D_DIV: begin
					if (cnt_q == CW'(1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				a_q    <= a;
				diff_q <= signed'({b[CB-1], b}) - signed'({a[CB-1], a});
				off_q  <= off;
				span_q <= span;
			end
			D_MUL: begin
				neg_q <= prod[PW-1];
				// rounding: (2|num| + span) / (2 span)
				num_q <= NW'({mag, 1'b0}) + NW'(span_q);
				den_q <= {span_q, 1'b0};
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CW'(NW);
			end
			D_DIV: begin
				rem_q <= rem_nxt;
				num_q <= {num_q[NW-2:0], 1'b0};
				quo_q <= {quo_q[NW-2:0], qbit};
				cnt_q <= cnt_q - CW'(1);
			end
			D_FIN: begin
				res_q <= cgr_pkg::clamp_out(v);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> rtl/core/color_gradient_ramp_unit.sv
// Color ramp over up to MAX_MARKS marks, one mark per cell of a chain. A write request
// (kind 0) sets or clears one slot. A query request (kind 1) walks the chain one cell per
// cycle, picking the lower and upper marks, then four per-channel units multiply and run
// a one-bit-per-cycle restoring divide for the rounded interpolation. The divide is
// skipped when the two marks share a place or the table is empty. One query is in flight
// at a time; a finished result waits in the output register while the next request is
// taken.
module color_gradient_ramp_unit #(
	parameter int MAX_MARKS    = 16,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [cgr_pkg::SLOT_W-1:0]        slot,
	input  logic                              slot_valid,
	input  logic [cgr_pkg::PLACE_W-1:0]       place,
	input  logic signed [CHANNEL_BITS-1:0]    mark_red,
	input  logic signed [CHANNEL_BITS-1:0]    mark_green,
	input  logic signed [CHANNEL_BITS-1:0]    mark_blue,
	input  logic signed [CHANNEL_BITS-1:0]    mark_alpha,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cgr_pkg::OUT_W-1:0]         out_red,
	output logic [cgr_pkg::OUT_W-1:0]         out_green,
	output logic [cgr_pkg::OUT_W-1:0]         out_blue,
	output logic [cgr_pkg::OUT_W-1:0]         out_alpha,
	output logic                              table_empty
);

	localparam int CB = CHANNEL_BITS;
	localparam int NCH = cgr_pkg::NCH;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_DONE} state_t;

	state_t                                  state_q;
	logic                                    out_valid_q;
	logic [NCH-1:0][cgr_pkg::OUT_W-1:0]      pend_q;
	logic                                    pend_empty_q;
	logic [NCH-1:0][cgr_pkg::OUT_W-1:0]      out_q;
	logic                                    out_empty_q;

	logic                                    acc;
	logic                                    acc_query;
	logic                                    acc_write;
	logic [NCH-1:0][CB-1:0]                  wr_rgba;

	logic [MAX_MARKS:0]                      tok;
	logic [cgr_pkg::PLACE_W-1:0]             qv   [MAX_MARKS+1];
	cgr_pkg::cand_t                          cand [MAX_MARKS+1];
	logic [cgr_pkg::NSEL-1:0][NCH-1:0][CB-1:0] sel [MAX_MARKS+1];

	cgr_pkg::cand_t                          c_end;
	logic [cgr_pkg::PLACE_W-1:0]             lo_place;
	logic [cgr_pkg::PLACE_W-1:0]             up_place;
	logic [NCH-1:0][CB-1:0]                  lo_rgba;
	logic [NCH-1:0][CB-1:0]                  up_rgba;
	logic [cgr_pkg::PLACE_W-1:0]             span;
	logic [cgr_pkg::PLACE_W-1:0]             off;
	logic                                    div_start;
	logic [NCH-1:0]                          div_done;
	logic [NCH-1:0][cgr_pkg::OUT_W-1:0]      div_res;
	logic [NCH-1:0][cgr_pkg::OUT_W-1:0]      lo_clamped;

	assign in_stall  = state_q != S_IDLE;
	assign acc       = in_valid && !in_stall;
	assign acc_query = acc && kind == cgr_pkg::KIND_QUERY;
	assign acc_write = acc && kind == cgr_pkg::KIND_WRITE;
	assign wr_rgba   = {mark_alpha, mark_blue, mark_green, mark_red};

	assign tok[0]  = acc_query;
	assign qv[0]   = place;
	assign cand[0] = '0;
	assign sel[0]  = '0;

	for (genvar i = 0; i < MAX_MARKS; i++) begin : g_cell
		cgr_cell #(
			.CB  (CB)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (acc_write && 32'(slot) == i),
			.wr_used  (slot_valid),
			.wr_place (place),
			.wr_rgba  (wr_rgba),
			.tok_in   (tok[i]),
			.q_in     (qv[i]),
			.cand_in  (cand[i]),
			.sel_in   (sel[i]),
			.tok_out  (tok[i+1]),
			.q_out    (qv[i+1]),
			.cand_out (cand[i+1]),
			.sel_out  (sel[i+1])
		);
	end

	always_comb begin
		c_end    = cand[MAX_MARKS];
		lo_place = c_end.lb_ok ? c_end.lb_place : c_end.mn_place;
		lo_rgba  = c_end.lb_ok ? sel[MAX_MARKS][cgr_pkg::SEL_LB]
		                       : sel[MAX_MARKS][cgr_pkg::SEL_MN];
		up_place = c_end.ua_ok ? c_end.ua_place : c_end.mx_place;
		up_rgba  = c_end.ua_ok ? sel[MAX_MARKS][cgr_pkg::SEL_UA]
		                       : sel[MAX_MARKS][cgr_pkg::SEL_MX];
		span = up_place > lo_place ? up_place - lo_place : '0;
		off  = qv[MAX_MARKS] - lo_place;
		for (int c = 0; c < NCH; c++) begin
			lo_clamped[c] = cgr_pkg::clamp_out(
				{{(cgr_pkg::CLAMP_W-CB){lo_rgba[c][CB-1]}}, lo_rgba[c]});
		end
		div_start = state_q == S_SCAN && tok[MAX_MARKS] && c_end.mn_ok && span != '0;
	end

	for (genvar c = 0; c < NCH; c++) begin : g_div
		cgr_div #(
			.CB (CB)
		) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.a      (lo_rgba[c]),
			.b      (up_rgba[c]),
			.off    (off),
			.span   (span),
			.done   (div_done[c]),
			.res    (div_res[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_query) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tok[MAX_MARKS]) begin
						state_q <= div_start ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_done[0]) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && tok[MAX_MARKS]) begin
			pend_empty_q <= !c_end.mn_ok;
			pend_q       <= c_end.mn_ok ? lo_clamped : '0;
		end
		if (state_q == S_DIV && div_done[0]) begin
			pend_q <= div_res;
		end
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_q       <= pend_q;
			out_empty_q <= pend_empty_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = out_q[0];
	assign out_green   = out_q[1];
	assign out_blue    = out_q[2];
	assign out_alpha   = out_q[3];
	assign table_empty = out_empty_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok[MAX_MARKS:1]) <= 1)
		else $error("more than one query in the chain");

	a_tok_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_MARKS] |-> state_q == S_SCAN)
		else $error("query left the chain outside scan");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done[0] |-> state_q == S_DIV)
		else $error("divide finished outside divide state");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == S_DIV)
		else $error("divide started without entering divide state");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_empty |->
		out_red == '0 && out_green == '0 && out_blue == '0 && out_alpha == '0)
		else $error("empty table result carries color");

endmodule

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MARKS = 16;
	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE = 80;
	localparam int SLOT_W = cgr_pkg::SLOT_W;
	localparam int PLACE_W = cgr_pkg::PLACE_W;
	localparam int OUT_W = cgr_pkg::OUT_W;
	localparam int NCH = cgr_pkg::NCH;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = cgr_pkg::KIND_WRITE;
	logic [SLOT_W-1:0] slot = '0;
	logic slot_valid = 1'b0;
	logic [PLACE_W-1:0] place = '0;
	logic signed [15:0] mark_red = '0, mark_green = '0, mark_blue = '0, mark_alpha = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] out_red, out_green, out_blue, out_alpha;
	logic table_empty;

	color_gradient_ramp_unit #(.MAX_MARKS(MARKS), .CHANNEL_BITS(16)) DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	typedef struct packed {
		logic k;
		logic [SLOT_W-1:0] s;
		logic sv;
		logic [PLACE_W-1:0] p;
		logic signed [15:0] r, g, b, a;
	} req_t;

	localparam int REQ_W = $bits(req_t);

	typedef struct packed {
		logic [OUT_W-1:0] r, g, b, a;
		logic empty;
	} color_t;

	// ramp shadow
	logic ramp_used [MARKS];
	logic [PLACE_W-1:0] ramp_place [MARKS];
	logic signed [15:0] ramp_ch [MARKS][NCH];

	color_t colors_due [$];
	int errors = 0;
	int n_sent = 0, n_seen = 0, n_empty = 0;
	int send_idle = 18, recv_idle = 63;
	bit hold_rx = 0;
	int idle_cycles = 0;

	function automatic void due_add(color_t c);
		colors_due = {colors_due, c};
	endfunction

	function automatic logic signed [63:0] lerp(logic signed [63:0] a, logic signed [63:0] b,
			logic [63:0] off, logic [63:0] span);
		logic signed [63:0] num;
		logic [63:0] mag, q;
		num = $signed(off) * (b - a);
		mag = num < 0 ? -num : num;
		q = (2 * mag + span) / (2 * span);
		return num < 0 ? a - $signed(q) : a + $signed(q);
	endfunction

	function automatic void ramp_apply(req_t rq, output bit has, output color_t c);
		int lb, ua, mn, mx, lo, up;
		logic [63:0] span;
		logic signed [63:0] v;
		logic signed [15:0] ch [NCH];
		has = 0;
		c = '0;
		ch[0] = rq.r; ch[1] = rq.g; ch[2] = rq.b; ch[3] = rq.a;
		if (rq.k == cgr_pkg::KIND_WRITE) begin
			ramp_used[rq.s] = rq.sv;
			if (rq.sv) begin
				ramp_place[rq.s] = rq.p;
				for (int i = 0; i < NCH; i++) ramp_ch[rq.s][i] = ch[i];
			end
			return;
		end
		has = 1;
		lb = -1; ua = -1; mn = -1; mx = -1;
		for (int i = 0; i < MARKS; i++) begin
			if (!ramp_used[i]) continue;
			if (mn < 0 || ramp_place[i] < ramp_place[mn]) mn = i;
			if (mx < 0 || ramp_place[i] > ramp_place[mx]) mx = i;
			if (ramp_place[i] < rq.p && (lb < 0 || ramp_place[i] > ramp_place[lb])) lb = i;
			if (ramp_place[i] >= rq.p && (ua < 0 || ramp_place[i] < ramp_place[ua])) ua = i;
		end
		if (mn < 0) begin
			c.empty = 1;
			return;
		end
		lo = lb >= 0 ? lb : mn;
		up = ua >= 0 ? ua : mx;
		span = ramp_place[up] > ramp_place[lo] ? ramp_place[up] - ramp_place[lo] : 0;
		for (int i = 0; i < NCH; i++) begin
			if (span == 0) v = ramp_ch[lo][i];
			else v = lerp(ramp_ch[lo][i], ramp_ch[up][i], rq.p - ramp_place[lo], span);
			if (v < 0) v = 0;
			if (v > 32767) v = 32767;
			case (i)
				0: c.r = v[14:0];
				1: c.g = v[14:0];
				2: c.b = v[14:0];
				default: c.a = v[14:0];
			endcase
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_seen);
	endtask

	// result side
	always @(posedge clk) begin
		color_t want;
		if (out_valid && !out_stall) begin
			if (colors_due.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = colors_due.pop_front();
				if (out_red != want.r) report_mismatch("red", out_red, want.r);
				if (out_green != want.g) report_mismatch("green", out_green, want.g);
				if (out_blue != want.b) report_mismatch("blue", out_blue, want.b);
				if (out_alpha != want.a) report_mismatch("alpha", out_alpha, want.a);
				if (table_empty != want.empty) report_mismatch("empty", table_empty, want.empty);
				if (table_empty) n_empty++;
			end
			n_seen++;
		end
		out_stall <= hold_rx ? 1'b1 : ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", colors_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// valid stays up between back-to-back requests and drops only while idling
	task automatic send(req_t rq, bit typed = 0, color_t typed_c = '0);
		bit has;
		color_t c;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= rq.k; slot <= rq.s; slot_valid <= rq.sv; place <= rq.p;
		mark_red <= rq.r; mark_green <= rq.g; mark_blue <= rq.b; mark_alpha <= rq.a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ramp_apply(rq, has, c);
		if (has) begin
			if (typed) due_add(typed_c);
			else due_add(c);
		end
		n_sent++;
	endtask

	function automatic req_t wr(int s, int sv, int p, int r, int g, int b, int a);
		req_t rq;
		rq.k = cgr_pkg::KIND_WRITE; rq.s = SLOT_W'(s); rq.sv = 1'(sv); rq.p = PLACE_W'(p);
		rq.r = 16'(r); rq.g = 16'(g); rq.b = 16'(b); rq.a = 16'(a);
		return rq;
	endfunction

	function automatic req_t qry(int p);
		req_t rq;
		rq = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
		rq.k = cgr_pkg::KIND_QUERY; rq.p = PLACE_W'(p);
		return rq;
	endfunction

	function automatic req_t rand_req();
		req_t rq;
		rq = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
		if ($urandom_range(3) == 0) rq.p = $urandom_range(3) == 0 ? 16'hffff : 16'h0000;
		if ($urandom_range(9) < 4) rq.k = cgr_pkg::KIND_WRITE;
		else rq.k = cgr_pkg::KIND_QUERY;
		if (rq.k == cgr_pkg::KIND_WRITE && $urandom_range(5) != 0) rq.sv = 1'b1;
		return rq;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (colors_due.size() != 0) @(posedge clk);
	endtask

	typedef struct {
		req_t rq;
		bit typed;
		color_t c;
	} row_t;

	row_t rows [$];

	function automatic void add_row(req_t rq, bit typed, color_t c);
		rows = {rows, row_t'{rq, typed, c}};
	endfunction

	initial begin
		for (int i = 0; i < MARKS; i++) ramp_used[i] = 0;
		add_row(qry(16'h8000), 1, '{0, 0, 0, 0, 1});
		add_row(wr(3, 1, 16'h4000, 16'h7fff, -32768, 16'h1000, 0), 0, '0);
		add_row(qry(16'h0000), 1, '{15'h7fff, 0, 15'h1000, 0, 0});
		add_row(qry(16'hffff), 1, '{15'h7fff, 0, 15'h1000, 0, 0});
		add_row(wr(9, 1, 16'hc000, -32768, 16'h7fff, 16'h3000, 16'h4000), 0, '0);
		add_row(qry(16'h8000), 0, '0);
		add_row(qry(16'h4000), 0, '0);
		add_row(qry(16'hc000), 0, '0);
		add_row(qry(16'h4001), 0, '0);
		add_row(wr(1, 1, 16'hc000, 16'h0100, 16'h0200, 16'h0300, 16'h0400), 0, '0);
		add_row(qry(16'hffff), 1, '{15'h0100, 15'h0200, 15'h0300, 15'h0400, 0});
		add_row(qry(16'hbfff), 0, '0);
		add_row(wr(0, 1, 16'h0000, 0, 16'h7fff, 0, 16'h7fff), 0, '0);
		add_row(wr(15, 1, 16'hffff, 16'h7fff, 0, 16'h7fff, 0), 0, '0);
		add_row(qry(16'h0000), 1, '{0, 15'h7fff, 0, 15'h7fff, 0});
		add_row(qry(16'hffff), 0, '0);
		add_row(qry(16'he000), 0, '0);
		add_row(wr(9, 0, 16'h1234, 0, 0, 0, 0), 0, '0);
		add_row(qry(16'h8000), 0, '0);
		for (int i = 0; i < 4; i++) add_row(wr(i * 5 % 16, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(wr(3, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(qry(16'h1111), 0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send(rows[i].rq, rows[i].typed, rows[i].c);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 18 : (ph == 1 ? 63 : 0);
			recv_idle = ph == 0 ? 63 : (ph == 1 ? 18 : 0);
			if (ph == 2) begin
				// long receiver hold so the block backs up its input
				fork
					begin
						hold_rx = 1;
						repeat (400) @(posedge clk);
						hold_rx = 0;
					end
				join_none
			end
			for (int n = 0; n < 260; n++) begin
				send(rand_req());
				if (n == 130) drain();
			end
			drain();
		end
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d requests, checked %0d colors (%0d from an empty table)",
			n_sent, n_seen, n_empty);
		if (errors == 0 && colors_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

>>> sim.f
rtl/core/cgr_pkg.sv
rtl/core/cgr_cell.sv
rtl/core/cgr_div.sv
rtl/core/color_gradient_ramp_unit.sv
tb/tb_top.sv
